### sv/ees_pkg.sv
// Package for the I2C EEPROM transaction sequencer.
// Holds field widths, operation, bus command, phase and register codes, and the result type.
// No dependencies.
package ees_pkg;

    // Field widths on the stream ports
    localparam int OP_W         = 3;
    localparam int ADDR_FIELD_W = 16;
    localparam int CNT_FIELD_W  = 16;
    localparam int BYTE_W       = 8;
    localparam int CMD_W        = 3;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 24;

    // Defaults for the top-level parameters
    localparam int ADDRESS_WIDTH_DEFAULT = 16;
    localparam int COUNT_WIDTH_DEFAULT   = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_BYTE_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_SIZE_LOG2     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT         = 2'd3;

    localparam int DEV_ADDR_W   = 7;
    localparam int ADDR_BYTES_W = 2;
    localparam int PAGE_LOG2_W  = 4;
    localparam int POLL_W       = 16;

    localparam logic [DEV_ADDR_W-1:0]   DEVICE_ADDRESS_RESET     = 7'd80;
    localparam logic [ADDR_BYTES_W-1:0] ADDRESS_BYTE_COUNT_RESET = 2'd1;
    localparam logic [PAGE_LOG2_W-1:0]  PAGE_SIZE_LOG2_RESET     = 4'd3;
    localparam logic [POLL_W-1:0]       POLL_LIMIT_RESET         = 16'd1000;

    // Input operations
    localparam logic [OP_W-1:0] OP_BEGIN_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_BEGIN_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ACK_RESP    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_RESP   = 3'd4;

    // Bus commands
    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NACK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_REPORT = 3'd6;

    // Sequencer phases
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_DEVW     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ADDRH    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ADDRL    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DEVR     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_RDATA    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WAITDATA = 4'd6;
    localparam logic [PHASE_W-1:0] PH_POLL     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WDATA    = 4'd8;

    // Results per input beat
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] bus_byte;
        logic [BYTE_W-1:0] read_data;
        logic              read_data_valid;
        logic              done_res;
        logic              success;
        logic              last;
    } res_t;

    function automatic res_t mk_res(input logic [CMD_W-1:0] cmd,
                                    input logic [BYTE_W-1:0] bus_byte,
                                    input logic [BYTE_W-1:0] read_data,
                                    input logic read_data_valid,
                                    input logic done_res,
                                    input logic success);
        res_t r;
        r.cmd             = cmd;
        r.bus_byte        = bus_byte;
        r.read_data       = read_data;
        r.read_data_valid = read_data_valid;
        r.done_res        = done_res;
        r.success         = success;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

### sv/i2c_eeprom_transaction_sequencer.sv
// I2C EEPROM transaction sequencer: turns random-read and page-write requests into
// byte-level bus commands. Depends on ees_pkg.
//
// Usage:
//   s_ channel: one beat per request or bus response. tuser carries the operation
//   (begin read, begin write, write data byte, ack response, read response).
//   m_ channel: bus commands (start, stop, send, read, ack, nack, report), one per
//   beat; tlast marks the final command caused by an input beat.
//   cfg_ port: device address, address byte count, page size, poll limit. Write
//   only while no result is pending.
// Timing: each input beat is decoded in the cycle it is accepted; its first result
//   shows on m_ in the next cycle when the output register is free, and the rest follow
//   one per cycle while m_tready stays high. Beats that produce no result can be taken
//   every cycle while the queue is empty. s_tready drops only while results beyond the
//   one held in the output register are queued.
// Stall: a stalled m_ side holds the output register and the queue; s_tready stays
//   low until the queue drains into the output register.
// Reset: aresetn (synchronous, active low) returns the sequencer to idle, clears
//   the queue and output valid, and loads the register reset values.
module i2c_eeprom_transaction_sequencer
    import ees_pkg::*;
#(
    parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: start_address[15:0], byte_count[31:16], data_byte[39:32],
    //        acknowledged[40], zero[47:41]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // tuser: operation[2:0]
    input  logic [OP_W-1:0]        s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: bus_byte[7:0], read_data[15:8], read_data_valid[16], done_res[17],
    //        success[18], zero[23:19]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // tuser: bus_command[2:0]
    output logic [CMD_W-1:0]       m_tuser,
    output logic                   m_tlast
);

    // configuration registers
    logic [DEV_ADDR_W-1:0]   dev_addr_reg;
    logic [ADDR_BYTES_W-1:0] addr_bytes_reg;
    logic [PAGE_LOG2_W-1:0]  page_log2_reg;
    logic [POLL_W-1:0]       poll_limit_reg;

    // sequencer state
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     is_read_reg, is_read_next;
    logic [ADDRESS_WIDTH-1:0] cur_addr_reg, cur_addr_next;
    logic [COUNT_WIDTH-1:0]   bytes_left_reg, bytes_left_next;
    logic                     first_byte_reg, first_byte_next;
    logic [POLL_W-1:0]        poll_count_reg, poll_count_next;
    logic [BYTE_W-1:0]        held_data_reg, held_data_next;

    // result queue and output register
    res_t                 buf_reg [MAX_RES];
    logic [RES_IDX_W-1:0] head_reg, head_next;
    logic [RES_CNT_W-1:0] left_reg, left_next;
    res_t                 out_reg, out_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // decoded input beat
    logic                     s_accept;
    logic [OP_W-1:0]          in_op;
    logic [ADDRESS_WIDTH-1:0] in_addr;
    logic [COUNT_WIDTH-1:0]   in_cnt;
    logic [BYTE_W-1:0]        in_data;
    logic                     in_ack;

    res_t                 res_arr [MAX_RES];
    logic [RES_CNT_W-1:0] res_n;
    logic                 out_free;
    logic                 store_res;

    logic [ADDR_FIELD_W-1:0]  addr_wide;
    logic [BYTE_W-1:0]        addr_hi, addr_lo;
    logic [BYTE_W-1:0]        dev_wr, dev_rd;
    logic                     page_start;
    logic [ADDRESS_WIDTH-1:0] addr_inc;
    logic [COUNT_WIDTH-1:0]   left_dec;
    res_t                     first_addr_res;
    logic [PHASE_W-1:0]       first_addr_phase;

    assign s_tready = (left_reg == '0);
    assign s_accept = s_tvalid && s_tready;

    assign in_op   = s_tuser;
    assign in_addr = ADDRESS_WIDTH'(s_tdata[ADDR_FIELD_W-1:0]);
    assign in_cnt  = COUNT_WIDTH'(s_tdata[ADDR_FIELD_W +: CNT_FIELD_W]);
    assign in_data = s_tdata[ADDR_FIELD_W+CNT_FIELD_W +: BYTE_W];
    assign in_ack  = s_tdata[ADDR_FIELD_W+CNT_FIELD_W+BYTE_W];

    assign addr_wide = ADDR_FIELD_W'(cur_addr_reg);
    assign addr_hi   = addr_wide[15:8];
    assign addr_lo   = addr_wide[7:0];
    assign dev_wr    = {dev_addr_reg, 1'b0};
    assign dev_rd    = {dev_addr_reg, 1'b1};
    assign addr_inc  = cur_addr_reg + ADDRESS_WIDTH'(1);
    assign left_dec  = bytes_left_reg - COUNT_WIDTH'(1);

    // page boundary: address bits below page_size_log2 all zero
    always_comb begin
        page_start = 1'b1;
        for (int i = 0; i < ADDRESS_WIDTH; i++) begin
            if ((i < int'(page_log2_reg)) && cur_addr_reg[i]) begin
                page_start = 1'b0;
            end
        end
    end

    // first memory address byte: high byte when two address bytes are used
    always_comb begin
        if (addr_bytes_reg >= 2'd2) begin
            first_addr_res   = mk_res(CMD_SEND, addr_hi, '0, 1'b0, 1'b0, 1'b0);
            first_addr_phase = PH_ADDRH;
        end else begin
            first_addr_res   = mk_res(CMD_SEND, addr_lo, '0, 1'b0, 1'b0, 1'b0);
            first_addr_phase = PH_ADDRL;
        end
    end

    // decode one input beat into state updates and up to three results
    always_comb begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        cur_addr_next   = cur_addr_reg;
        bytes_left_next = bytes_left_reg;
        first_byte_next = first_byte_reg;
        poll_count_next = poll_count_reg;
        held_data_next  = held_data_reg;
        res_n           = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_arr[i] = '0;
        end

        if (s_accept) begin
            case (in_op)
                OP_BEGIN_READ: begin
                    if (phase_reg == PH_IDLE) begin
                        is_read_next    = 1'b1;
                        cur_addr_next   = in_addr;
                        bytes_left_next = in_cnt;
                        res_arr[0]      = mk_res(CMD_START, '0, '0, 1'b0, 1'b0, 1'b0);
                        res_arr[1]      = mk_res(CMD_SEND, dev_wr, '0, 1'b0, 1'b0, 1'b0);
                        res_n           = RES_CNT_W'(2);
                        phase_next      = PH_DEVW;
                    end
                end
                OP_BEGIN_WRITE: begin
                    if (phase_reg == PH_IDLE) begin
                        is_read_next    = 1'b0;
                        cur_addr_next   = in_addr;
                        bytes_left_next = in_cnt;
                        first_byte_next = 1'b1;
                        if (in_cnt == '0) begin
                            res_arr[0] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                            res_arr[1] = mk_res(CMD_REPORT, '0, '0, 1'b0, 1'b1, 1'b1);
                            res_n      = RES_CNT_W'(2);
                        end else begin
                            phase_next = PH_WAITDATA;
                        end
                    end
                end
                OP_WRITE_BYTE: begin
                    if (phase_reg == PH_WAITDATA) begin
                        held_data_next = in_data;
                        if (first_byte_reg || page_start) begin
                            // new page: stop, then poll for ack unless poll limit is 0
                            res_arr[0] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                            res_n      = RES_CNT_W'(3);
                            if (poll_limit_reg == '0) begin
                                res_arr[1] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                                res_arr[2] = mk_res(CMD_REPORT, '0, '0, 1'b0, 1'b1, 1'b0);
                                phase_next = PH_IDLE;
                            end else begin
                                poll_count_next = POLL_W'(1);
                                res_arr[1] = mk_res(CMD_START, '0, '0, 1'b0, 1'b0, 1'b0);
                                res_arr[2] = mk_res(CMD_SEND, dev_wr, '0, 1'b0, 1'b0, 1'b0);
                                phase_next = PH_POLL;
                            end
                        end else begin
                            res_arr[0] = mk_res(CMD_SEND, in_data, '0, 1'b0, 1'b0, 1'b0);
                            res_n      = RES_CNT_W'(1);
                            phase_next = PH_WDATA;
                        end
                    end
                end
                OP_ACK_RESP: begin
                    if (!(phase_reg inside {PH_IDLE, PH_RDATA, PH_WAITDATA})) begin
                        if (phase_reg == PH_POLL) begin
                            if (in_ack) begin
                                res_arr[0] = first_addr_res;
                                res_n      = RES_CNT_W'(1);
                                phase_next = first_addr_phase;
                            end else if (poll_count_reg >= poll_limit_reg) begin
                                res_arr[0] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                                res_arr[1] = mk_res(CMD_REPORT, '0, '0, 1'b0, 1'b1, 1'b0);
                                res_n      = RES_CNT_W'(2);
                                phase_next = PH_IDLE;
                            end else begin
                                poll_count_next = poll_count_reg + POLL_W'(1);
                                res_arr[0] = mk_res(CMD_START, '0, '0, 1'b0, 1'b0, 1'b0);
                                res_arr[1] = mk_res(CMD_SEND, dev_wr, '0, 1'b0, 1'b0, 1'b0);
                                res_n      = RES_CNT_W'(2);
                            end
                        end else if (!in_ack) begin
                            res_arr[0] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                            res_arr[1] = mk_res(CMD_REPORT, '0, '0, 1'b0, 1'b1, 1'b0);
                            res_n      = RES_CNT_W'(2);
                            phase_next = PH_IDLE;
                        end else begin
                            case (phase_reg)
                                PH_DEVW: begin
                                    res_arr[0] = first_addr_res;
                                    res_n      = RES_CNT_W'(1);
                                    phase_next = first_addr_phase;
                                end
                                PH_ADDRH: begin
                                    res_arr[0] = mk_res(CMD_SEND, addr_lo, '0,
                                                        1'b0, 1'b0, 1'b0);
                                    res_n      = RES_CNT_W'(1);
                                    phase_next = PH_ADDRL;
                                end
                                PH_ADDRL: begin
                                    if (is_read_reg) begin
                                        res_arr[0] = mk_res(CMD_START, '0, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_arr[1] = mk_res(CMD_SEND, dev_rd, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_n      = RES_CNT_W'(2);
                                        phase_next = PH_DEVR;
                                    end else begin
                                        res_arr[0] = mk_res(CMD_SEND, held_data_reg, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_n      = RES_CNT_W'(1);
                                        phase_next = PH_WDATA;
                                    end
                                end
                                PH_DEVR: begin
                                    if (bytes_left_reg == '0) begin
                                        res_arr[0] = mk_res(CMD_STOP, '0, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_arr[1] = mk_res(CMD_REPORT, '0, '0,
                                                            1'b0, 1'b1, 1'b1);
                                        res_n      = RES_CNT_W'(2);
                                        phase_next = PH_IDLE;
                                    end else begin
                                        res_arr[0] = mk_res(CMD_READ, '0, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_n      = RES_CNT_W'(1);
                                        phase_next = PH_RDATA;
                                    end
                                end
                                PH_WDATA: begin
                                    cur_addr_next   = addr_inc;
                                    bytes_left_next = left_dec;
                                    first_byte_next = 1'b0;
                                    if (left_dec == '0) begin
                                        res_arr[0] = mk_res(CMD_STOP, '0, '0,
                                                            1'b0, 1'b0, 1'b0);
                                        res_arr[1] = mk_res(CMD_REPORT, '0, '0,
                                                            1'b0, 1'b1, 1'b1);
                                        res_n      = RES_CNT_W'(2);
                                        phase_next = PH_IDLE;
                                    end else begin
                                        phase_next = PH_WAITDATA;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                OP_READ_RESP: begin
                    if (phase_reg == PH_RDATA) begin
                        bytes_left_next = left_dec;
                        if (left_dec != '0) begin
                            res_arr[0] = mk_res(CMD_ACK, '0, in_data, 1'b1, 1'b0, 1'b0);
                            res_arr[1] = mk_res(CMD_READ, '0, '0, 1'b0, 1'b0, 1'b0);
                            res_n      = RES_CNT_W'(2);
                        end else begin
                            // last byte: nack, then close the transaction
                            res_arr[0] = mk_res(CMD_NACK, '0, in_data, 1'b1, 1'b0, 1'b0);
                            res_arr[1] = mk_res(CMD_STOP, '0, '0, 1'b0, 1'b0, 1'b0);
                            res_arr[2] = mk_res(CMD_REPORT, '0, '0, 1'b0, 1'b1, 1'b1);
                            res_n      = RES_CNT_W'(3);
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        for (int i = 0; i < MAX_RES; i++) begin
            res_arr[i].last = (RES_CNT_W'(i + 1) == res_n);
        end
    end

    // output register fed from the queue, or straight from a fresh beat
    assign out_free  = !m_tvalid_reg || m_tready;
    assign store_res = s_accept && (res_n != '0);

    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        head_next     = head_reg;
        left_next     = left_reg;
        if (out_free) begin
            if (left_reg != '0) begin
                out_next      = buf_reg[head_reg];
                m_tvalid_next = 1'b1;
                head_next     = head_reg + RES_IDX_W'(1);
                left_next     = left_reg - RES_CNT_W'(1);
            end else if (store_res) begin
                out_next      = res_arr[0];
                m_tvalid_next = 1'b1;
                head_next     = RES_IDX_W'(1);
                left_next     = res_n - RES_CNT_W'(1);
            end else begin
                m_tvalid_next = 1'b0;
            end
        end else if (store_res) begin
            head_next = '0;
            left_next = res_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= DEVICE_ADDRESS_RESET;
            addr_bytes_reg <= ADDRESS_BYTE_COUNT_RESET;
            page_log2_reg  <= PAGE_SIZE_LOG2_RESET;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS:     dev_addr_reg   <= cfg_wdata[DEV_ADDR_W-1:0];
                REG_ADDRESS_BYTE_COUNT: addr_bytes_reg <= cfg_wdata[ADDR_BYTES_W-1:0];
                REG_PAGE_SIZE_LOG2:     page_log2_reg  <= cfg_wdata[PAGE_LOG2_W-1:0];
                REG_POLL_LIMIT:         poll_limit_reg <= cfg_wdata[POLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            is_read_reg    <= 1'b0;
            cur_addr_reg   <= '0;
            bytes_left_reg <= '0;
            first_byte_reg <= 1'b0;
            poll_count_reg <= '0;
            held_data_reg  <= '0;
            head_reg       <= '0;
            left_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            cur_addr_reg   <= cur_addr_next;
            bytes_left_reg <= bytes_left_next;
            first_byte_reg <= first_byte_next;
            poll_count_reg <= poll_count_next;
            held_data_reg  <= held_data_next;
            head_reg       <= head_next;
            left_reg       <= left_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (store_res) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_reg[i] <= res_arr[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.cmd;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b0, out_reg.success, out_reg.done_res, out_reg.read_data_valid,
                       out_reg.read_data, out_reg.bus_byte};

    // queued results always sit behind a valid output beat
    a_queue_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg != '0) |-> m_tvalid_reg)
        else $error("result queue holds beats while output register is empty");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= RES_CNT_W'(MAX_RES))
        else $error("result queue count exceeds its depth");

    // a begin read from idle always leaves an output beat valid in the next cycle
    a_begin_read_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_op == OP_BEGIN_READ) && (phase_reg == PH_IDLE)) |=> m_tvalid_reg)
        else $error("begin read produced no output beat");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_WDATA)
        else $error("sequencer phase out of range");

endmodule
